// ----- rtl/strle_pkg.sv -----
// ----------------------------------------------------------------------------
// strle_pkg: shared types and constants of the transparent sprite RLE encoder
// Holds buffer sizing, byte kind codes and sequencer states.
// ----------------------------------------------------------------------------
package strle_pkg;

    localparam int MAX_WIDTH = 32;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int CNT_W     = $clog2(MAX_WIDTH + 1);
    localparam int CFG_W     = 6;
    localparam int PIX_W     = 8;

    localparam logic [CFG_W-1:0] WIDTH_RST = CFG_W'(32);

    typedef enum logic [1:0] {
        KIND_SKIP = 2'd0,
        KIND_LEN  = 2'd1,
        KIND_DATA = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_LEN,
        ST_DATA,
        ST_TAIL
    } t_state;

endpackage

// ----- rtl/sprite_transparent_rle_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// sprite_transparent_rle_encoder_unit: transparent sprite run-length encoder
// Turns raster palette pixels into skip / run-length / opaque data records.
// ----------------------------------------------------------------------------
// Output: the first result of a pixel is loaded into the output register
//   from the registered record plan; further results follow it in order.
// Input flow: a pixel that causes N > 0 results (N up to 34, set by the one
//   output loader and the buffer read port) holds the input stalled until
//   its last result is loaded; a pixel that causes no result never stalls it.
// Reset: synchronous, active low; clears sequencer, counters and output
//   valid, and sets the line width to 32. The run buffer is not cleared.
// ----------------------------------------------------------------------------
module sprite_transparent_rle_encoder_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [strle_pkg::CFG_W-1:0]   i_cfg_data,
    // pixel input
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [strle_pkg::PIX_W-1:0]   i_pixel,
    // encoded output
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [7:0]                    o_code_byte,
    output logic [1:0]                    o_byte_kind,
    output logic                          o_line_end,
    output logic                          o_last
);

    localparam int CW = strle_pkg::CNT_W;
    localparam int FW = strle_pkg::CFG_W;
    localparam int AW = strle_pkg::ADDR_W;
    localparam logic [FW-1:0] MAX_W = FW'(strle_pkg::MAX_WIDTH);
    localparam logic [CW-1:0] MAX_C = CW'(strle_pkg::MAX_WIDTH);

    // line state
    logic [FW-1:0]  r_width;
    logic [FW-1:0]  r_column, n_column;
    logic           r_in_run, n_in_run;
    logic [CW-1:0]  r_skip,   n_skip;
    logic [CW-1:0]  r_run,    n_run;

    // record plan captured with the pixel
    strle_pkg::t_state r_state, n_state;
    logic [CW-1:0]  r_head_val, n_head_val;
    logic           r_head_end, n_head_end;
    logic           r_flush,    n_flush;
    logic           r_tail,     n_tail;
    logic           r_eol,      n_eol;
    logic [CW-1:0]  r_cnt,      n_cnt;
    logic [CW-1:0]  r_pos,      n_pos;

    // run buffer and its registered read port
    logic [strle_pkg::PIX_W-1:0] r_mem [strle_pkg::MAX_WIDTH];
    logic [strle_pkg::PIX_W-1:0] r_rd;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;

    // output register
    logic                   r_o_valid;
    logic [7:0]             r_o_byte;
    strle_pkg::t_kind       r_o_kind;
    logic                   r_o_end;
    logic                   r_o_last;

    logic                   load;
    logic [7:0]             ld_byte;
    strle_pkg::t_kind       ld_kind;
    logic                   ld_end;
    logic                   ld_last;

    logic           accept;
    logic           out_free;
    logic [FW-1:0]  w_eff;
    logic           eol;
    logic           opaque;
    logic           data_final;

    assign o_stall  = (r_state != strle_pkg::ST_IDLE);
    assign accept   = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;
    assign opaque   = (i_pixel != '0);

    // Effective width: zero acts as one, oversize clamps to the buffer.
    always_comb begin
        if (r_width == '0) begin
            w_eff = FW'(1);
        end else if (r_width > MAX_W) begin
            w_eff = MAX_W;
        end else begin
            w_eff = r_width;
        end
        eol = ({1'b0, r_column} + (FW+1)'(1)) >= {1'b0, w_eff};
    end

    // Front end: update line state and plan the records of this pixel.
    always_comb begin
        n_column   = r_column;
        n_in_run   = r_in_run;
        n_skip     = r_skip;
        n_run      = r_run;
        n_head_val = r_head_val;
        n_head_end = r_head_end;
        n_flush    = r_flush;
        n_tail     = r_tail;
        n_eol      = r_eol;
        n_cnt      = r_cnt;
        wr_en      = 1'b0;
        wr_addr    = '0;
        if (accept) begin
            n_head_end = 1'b0;
            n_flush    = 1'b0;
            n_tail     = 1'b0;
            n_eol      = eol;
            if (!r_in_run) begin
                if (!opaque) begin
                    // transparent in skip phase: count, report only at line end
                    n_skip     = r_skip + CW'(1);
                    n_head_val = r_skip + CW'(1);
                    n_head_end = 1'b1;
                end else begin
                    // open a run: skip record first, pixel into slot zero
                    n_head_val = r_skip;
                    n_skip     = '0;
                    n_in_run   = 1'b1;
                    n_run      = CW'(1);
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    n_flush    = eol;
                    n_cnt      = CW'(1);
                end
            end else begin
                if (!opaque) begin
                    // close the run, start a new skip of one
                    n_flush  = 1'b1;
                    n_cnt    = r_run;
                    n_tail   = eol;
                    n_in_run = 1'b0;
                    n_skip   = CW'(1);
                    n_run    = '0;
                end else begin
                    if (r_run < MAX_C) begin
                        wr_en   = 1'b1;
                        wr_addr = r_run[AW-1:0];
                        n_run   = r_run + CW'(1);
                        n_cnt   = r_run + CW'(1);
                    end else begin
                        n_cnt   = r_run;
                    end
                    n_flush = eol;
                end
            end
            if (eol) begin
                n_column = '0;
                n_in_run = 1'b0;
                n_skip   = '0;
                n_run    = '0;
            end else begin
                n_column = r_column + FW'(1);
            end
        end
    end

    assign data_final = ((r_pos + CW'(1)) == r_cnt);

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            strle_pkg::ST_IDLE: begin
                if (accept) begin
                    if ((!r_in_run && !opaque && eol) || (!r_in_run && opaque)) begin
                        n_state = strle_pkg::ST_HEAD;
                    end else if (n_flush) begin
                        n_state = strle_pkg::ST_LEN;
                    end
                end
            end
            strle_pkg::ST_HEAD: begin
                if (out_free) begin
                    n_state = r_flush ? strle_pkg::ST_LEN : strle_pkg::ST_IDLE;
                end
            end
            strle_pkg::ST_LEN: begin
                if (out_free) begin
                    n_state = strle_pkg::ST_DATA;
                end
            end
            strle_pkg::ST_DATA: begin
                if (out_free && data_final) begin
                    n_state = r_tail ? strle_pkg::ST_TAIL : strle_pkg::ST_IDLE;
                end
            end
            strle_pkg::ST_TAIL: begin
                if (out_free) begin
                    n_state = strle_pkg::ST_IDLE;
                end
            end
            default: n_state = strle_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: what the output register loads, buffer reads.
    always_comb begin
        load    = 1'b0;
        ld_byte = '0;
        ld_kind = strle_pkg::KIND_SKIP;
        ld_end  = 1'b0;
        ld_last = 1'b0;
        rd_en   = 1'b0;
        rd_addr = '0;
        n_pos   = r_pos;
        case (r_state)
            strle_pkg::ST_HEAD: begin
                load    = out_free;
                ld_byte = 8'(r_head_val);
                ld_kind = strle_pkg::KIND_SKIP;
                ld_end  = r_head_end;
                ld_last = !r_flush;
            end
            strle_pkg::ST_LEN: begin
                // prefetch the first buffered pixel with the length byte
                load    = out_free;
                ld_byte = 8'(r_cnt);
                ld_kind = strle_pkg::KIND_LEN;
                rd_en   = out_free;
                rd_addr = '0;
                if (out_free) begin
                    n_pos = '0;
                end
            end
            strle_pkg::ST_DATA: begin
                // the last data byte ends the line only when no skip follows
                load    = out_free;
                ld_byte = r_rd;
                ld_kind = strle_pkg::KIND_DATA;
                ld_end  = data_final && r_eol && !r_tail;
                ld_last = data_final && !r_tail;
                rd_en   = out_free;
                rd_addr = AW'(r_pos + CW'(1));
                if (out_free) begin
                    n_pos = r_pos + CW'(1);
                end
            end
            strle_pkg::ST_TAIL: begin
                load    = out_free;
                ld_byte = 8'd1;
                ld_kind = strle_pkg::KIND_SKIP;
                ld_end  = 1'b1;
                ld_last = 1'b1;
            end
            default: begin
                load = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= strle_pkg::WIDTH_RST;
            r_column  <= '0;
            r_in_run  <= 1'b0;
            r_skip    <= '0;
            r_run     <= '0;
            r_state   <= strle_pkg::ST_IDLE;
            r_flush   <= 1'b0;
            r_tail    <= 1'b0;
            r_eol     <= 1'b0;
            r_head_end <= 1'b0;
            r_cnt     <= '0;
            r_pos     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_width <= i_cfg_data;
            end
            r_column   <= n_column;
            r_in_run   <= n_in_run;
            r_skip     <= n_skip;
            r_run      <= n_run;
            r_state    <= n_state;
            r_flush    <= n_flush;
            r_tail     <= n_tail;
            r_eol      <= n_eol;
            r_head_end <= n_head_end;
            r_cnt      <= n_cnt;
            r_pos      <= n_pos;
            if (load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge i_clk) begin
        r_head_val <= n_head_val;
        if (load) begin
            r_o_byte <= ld_byte;
            r_o_kind <= ld_kind;
            r_o_end  <= ld_end;
            r_o_last <= ld_last;
        end
    end

    // Run buffer: written with the pixel, read one byte ahead of the output.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_pixel;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    assign o_valid     = r_o_valid;
    assign o_code_byte = r_o_byte;
    assign o_byte_kind = r_o_kind;
    assign o_line_end  = r_o_end;
    assign o_last      = r_o_last;

    // A run being drained always has one to MAX_WIDTH bytes.
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == strle_pkg::ST_LEN) |-> (r_cnt != '0 && r_cnt <= MAX_C))
        else $error("run length out of range at flush");

    // Drain position stays inside the run.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == strle_pkg::ST_DATA) |-> (r_pos < r_cnt))
        else $error("drain position beyond run length");

    // An open run holds at least one buffered pixel.
    a_run_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_run |-> (r_run != '0 && r_run <= MAX_C))
        else $error("open run with bad count");

    // The final byte of a line is the final result of its pixel.
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_end) |-> r_o_last)
        else $error("line end without last");

    // A length byte is always followed by its data.
    a_len_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_kind == strle_pkg::KIND_LEN) |-> !r_o_last)
        else $error("length byte marked last");

endmodule

// ----- bench/sprite_rle_checker.sv -----
// ----------------------------------------------------------------------------
// sprite_rle_checker: encoded byte stream checker for the sprite RLE encoder
// Follows the pixel, configuration and output channels, encodes every pixel
// transaction on its own copy of the line state and compares each output
// transaction, field by field, with the oldest expected byte.
// ----------------------------------------------------------------------------
module sprite_rle_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [strle_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                          i_valid,
    input  logic                          o_stall,
    input  logic [strle_pkg::PIX_W-1:0]   i_pixel,
    input  logic                          o_valid,
    input  logic                          i_stall,
    input  logic [7:0]                    o_code_byte,
    input  logic [1:0]                    o_byte_kind,
    input  logic                          o_line_end,
    input  logic                          o_last,
    output int                            fail_count,
    output int                            pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CFG_W     = strle_pkg::CFG_W;
    localparam int PIX_W     = strle_pkg::PIX_W;
    localparam int CNT_W     = strle_pkg::CNT_W;
    localparam int ADDR_W    = strle_pkg::ADDR_W;
    localparam int MAX_WIDTH = strle_pkg::MAX_WIDTH;

    typedef struct packed {
        logic [7:0]       code;
        strle_pkg::t_kind kind;
        logic             line_end;
        logic             last;
    } t_enc_byte;

    t_enc_byte expected_bytes[$];
    t_enc_byte pixel_bytes[$];

    // encoder line state
    logic [CFG_W-1:0] line_width;
    logic [5:0]       column;
    logic             in_run;
    logic [CNT_W-1:0] skip_count;
    logic [CNT_W-1:0] run_count;
    logic [7:0]       run_buffer [MAX_WIDTH];

    task automatic emit(input logic [7:0] code, input strle_pkg::t_kind kind,
                        input logic eol);
        t_enc_byte b;
        b.code     = code;
        b.kind     = kind;
        b.line_end = eol;
        b.last     = 1'b0;
        pixel_bytes.push_back(b);
    endtask

    task automatic flush_run(input logic eol);
        emit(8'(run_count), strle_pkg::KIND_LEN, eol && run_count == 0);
        for (int i = 0; i < int'(run_count) && i < MAX_WIDTH; i++) begin
            emit(run_buffer[i], strle_pkg::KIND_DATA, eol && (i + 1 == int'(run_count)));
        end
        run_count = '0;
    endtask

    task automatic encode_pixel(input logic [PIX_W-1:0] px);
        int   eff_width;
        logic eol;
        t_enc_byte b;
        eff_width = (line_width == 0) ? 1 :
                    (int'(line_width) > MAX_WIDTH) ? MAX_WIDTH : int'(line_width);
        eol = (int'(column) + 1 >= eff_width);
        pixel_bytes.delete();
        if (!in_run) begin
            if (px == 0) begin
                skip_count = skip_count + 1'b1;
                if (eol) emit(8'(skip_count), strle_pkg::KIND_SKIP, 1'b1);
            end else begin
                emit(8'(skip_count), strle_pkg::KIND_SKIP, 1'b0);
                skip_count    = '0;
                in_run        = 1'b1;
                run_buffer[0] = px;
                run_count     = CNT_W'(1);
                if (eol) flush_run(1'b1);
            end
        end else begin
            if (px == 0) begin
                flush_run(1'b0);
                in_run     = 1'b0;
                skip_count = CNT_W'(1);
                if (eol) emit(8'(skip_count), strle_pkg::KIND_SKIP, 1'b1);
            end else begin
                if (int'(run_count) < MAX_WIDTH) begin
                    run_buffer[run_count[ADDR_W-1:0]] = px;
                    run_count = run_count + 1'b1;
                end
                if (eol) flush_run(1'b1);
            end
        end
        if (eol) begin
            column     = '0;
            in_run     = 1'b0;
            skip_count = '0;
            run_count  = '0;
        end else begin
            column = column + 1'b1;
        end
        if (pixel_bytes.size() > 0) begin
            b = pixel_bytes[$];
            b.last = 1'b1;
            pixel_bytes[pixel_bytes.size() - 1] = b;
        end
        foreach (pixel_bytes[i]) expected_bytes.push_back(pixel_bytes[i]);
    endtask

    task automatic check_byte();
        t_enc_byte want;
        if (expected_bytes.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected byte: code %0d kind %0d line_end %0b last %0b",
                         o_code_byte, o_byte_kind, o_line_end, o_last);
        end else begin
            want = expected_bytes.pop_front();
            if (o_code_byte !== want.code || o_byte_kind !== want.kind ||
                o_line_end !== want.line_end || o_last !== want.last) begin
                fail_count++;
                if (fail_count <= 10)
                    $display({"mismatch: expected code %0d kind %0d line_end %0b last %0b,",
                              " got code %0d kind %0d line_end %0b last %0b"},
                             want.code, want.kind, want.line_end, want.last,
                             o_code_byte, o_byte_kind, o_line_end, o_last);
            end
        end
    endtask

    // a pixel taken at the same edge as a width write still sees the old width
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            line_width = strle_pkg::WIDTH_RST;
            column     = '0;
            in_run     = 1'b0;
            skip_count = '0;
            run_count  = '0;
            expected_bytes.delete();
        end else begin
            if (o_valid && !i_stall) check_byte();
            if (i_valid && !o_stall) encode_pixel(i_pixel);
            if (i_cfg_we) line_width = i_cfg_data;
        end
        pending_count = expected_bytes.size();
    end

endmodule

// ----- bench/sprite_transparent_rle_encoder_unit_tb.sv -----
// ----------------------------------------------------------------------------
// sprite_transparent_rle_encoder_unit_tb: testbench of the sprite RLE encoder
// Drives a short directed pixel sequence and then segments of random runs at
// several line widths and idle patterns; a checker beside the block predicts
// and compares the encoded byte stream.
// ----------------------------------------------------------------------------
module sprite_transparent_rle_encoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CFG_W     = strle_pkg::CFG_W;
    localparam int PIX_W     = strle_pkg::PIX_W;
    localparam int MAX_WIDTH = strle_pkg::MAX_WIDTH;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 300;
    localparam int SEG_ITEMS      = 36;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_cfg_we   = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             i_valid    = 1'b0;
    logic [PIX_W-1:0] i_pixel    = '0;
    logic             i_stall    = 1'b0;
    logic             o_stall;
    logic             o_valid;
    logic [7:0]       o_code_byte;
    logic [1:0]       o_byte_kind;
    logic             o_line_end;
    logic             o_last;

    int fail_count;
    int pending_count;

    // idle percentages of the sender and the receiver
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // long receiver hold-off, requested by the stimulus, counted by the receiver
    bit hold_request = 1'b0;
    int hold_left    = 0;

    // state of the random run generator
    int  seg_left   = 0;
    bit  seg_opaque = 1'b0;

    int idle_cycles = 0;

    sprite_transparent_rle_encoder_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pixel     (i_pixel),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_code_byte (o_code_byte),
        .o_byte_kind (o_byte_kind),
        .o_line_end  (o_line_end),
        .o_last      (o_last)
    );

    sprite_rle_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel       (i_pixel),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_code_byte   (o_code_byte),
        .o_byte_kind   (o_byte_kind),
        .o_line_end    (o_line_end),
        .o_last        (o_last),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Receiver: stall at random, or hold off for a long stretch on request.
    // Exactly one assignment to i_stall per falling edge.
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: count cycles with no transaction on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one pixel transaction and return at the edge that takes it.
    // Valid is only lowered when an idle cycle is chosen, so back-to-back
    // transactions keep it high without a second assignment in one step.
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Drop valid, wait until every expected byte has come out, then keep waiting
    // so that a pixel that caused no byte is also through the block.
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_width(input logic [CFG_W-1:0] width);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= width;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic set_idle_mode(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Mostly runs of transparent or opaque pixels, some plain noise.
    function automatic logic [PIX_W-1:0] next_pixel();
        if ($urandom_range(99) < 20) begin
            return $urandom_range(1) ? PIX_W'(0) : PIX_W'($urandom_range(255));
        end
        if (seg_left == 0) begin
            seg_opaque = $urandom_range(1);
            seg_left   = ($urandom_range(9) == 0) ? $urandom_range(9, 40)
                                                 : $urandom_range(1, 8);
        end
        seg_left--;
        return seg_opaque ? PIX_W'($urandom_range(1, 255)) : PIX_W'(0);
    endfunction

    initial begin
        logic [CFG_W-1:0] seg_width [7];
        logic [PIX_W-1:0] px;
        bit               full_line;

        seg_width = '{6'd1, 6'd63, 6'd5, 6'd1, 6'd32, 6'd33, 6'd0};
        seg_width[6] = CFG_W'($urandom_range(2, 31));

        // hold reset from the start, release it once
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part ----
        set_idle_mode(31, 84);

        // zero width acts as one: every pixel is a line of its own
        write_width(6'd0);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd1);

        // width 3: all-transparent line (silent pixels), a line ending in
        // a zero, and a line that starts transparent and ends in a run
        write_width(6'd3);
        send_pixel(8'd0);
        send_pixel(8'd0);
        send_pixel(8'd0);
        send_pixel(8'd170);
        send_pixel(8'd85);
        send_pixel(8'd0);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd128);

        // shrink the width mid-line: column is past the new last column,
        // so the next pixel closes the line
        write_width(6'd8);
        send_pixel(8'd7);
        send_pixel(8'd0);
        write_width(6'd2);
        send_pixel(8'd9);

        // ---- random part ----
        for (int seg = 0; seg < 7; seg++) begin
            write_width(seg_width[seg]);
            if (seg < 2) begin
                set_idle_mode(31, 84);
            end else if (seg < 4) begin
                set_idle_mode(84, 31);
            end else begin
                set_idle_mode(0, 0);
            end
            // width 1 before these segments leaves the column at zero, so a
            // leading opaque stretch is one full line of the widest run
            full_line = (seg == 1 || seg == 4);
            for (int k = 0; k < SEG_ITEMS; k++) begin
                if (full_line && k < MAX_WIDTH) begin
                    px = PIX_W'($urandom_range(1, 255));
                end else begin
                    px = next_pixel();
                end
                // hold off the receiver while pixels keep coming
                if ((seg == 1 && k == 4) || (seg == 4 && k == 28)) hold_request = 1'b1;
                // pause the sender until the stream has caught up
                if (seg == 2 && k == 20) drain_results();
                send_pixel(px);
            end
        end

        // ---- wrap up ----
        drain_results();
        repeat (40) @(negedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
